@@ hw/rtl/gcmp_pkg.sv @@
package gcmp_pkg;

   // Coordinate and field widths.
   localparam int COORD_WIDTH = 16;
   localparam int POS_WIDTH   = 16;
   localparam int PULSE_WIDTH = 25;
   localparam int STEPS_WIDTH = 8;
   localparam int FEED_WIDTH  = 8;
   localparam int CODE_WIDTH  = 7;
   localparam int CHAR_WIDTH  = 8;
   localparam int KIND_WIDTH  = 2;

   // Width of the accumulator update before saturation.
   localparam int ACC_EXT_WIDTH = COORD_WIDTH + 4;
   // Width of the command code update before saturation.
   localparam int CODE_EXT_WIDTH = 10;
   // Width of the pulse product, never narrower than the pulse field.
   localparam int PROD_WIDTH = (COORD_WIDTH + STEPS_WIDTH + 1 > PULSE_WIDTH) ?
                               (COORD_WIDTH + STEPS_WIDTH + 1) : PULSE_WIDTH;

   localparam logic [PULSE_WIDTH-1:0] PULSE_MAX = {PULSE_WIDTH{1'b1}};
   localparam logic [COORD_WIDTH-1:0] COORD_MAX = {COORD_WIDTH{1'b1}};
   localparam logic [FEED_WIDTH-1:0]  FEED_MAX  = {FEED_WIDTH{1'b1}};
   localparam logic [CODE_WIDTH-1:0]  CODE_MAX  = 7'd99;
   localparam logic [STEPS_WIDTH-1:0] STEPS_RESET = 8'd1;

   // Depth of the queue between the parser and the segment generator.
   localparam int LINE_FIFO_DEPTH = 4;
   localparam int LINE_FIFO_ADDR  = $clog2(LINE_FIFO_DEPTH);

   // Characters of interest.
   localparam logic [CHAR_WIDTH-1:0] CHAR_LF   = 8'd10;
   localparam logic [CHAR_WIDTH-1:0] CHAR_CR   = 8'd13;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_G    = 8'h47;
   localparam logic [CHAR_WIDTH-1:0] CHAR_M    = 8'h4D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_X    = 8'h58;
   localparam logic [CHAR_WIDTH-1:0] CHAR_Y    = 8'h59;
   localparam logic [CHAR_WIDTH-1:0] CHAR_F    = 8'h46;

   // Command codes.
   localparam logic [CODE_WIDTH-1:0] CMD_RAPID     = 7'd0;
   localparam logic [CODE_WIDTH-1:0] CMD_LINEAR    = 7'd1;
   localparam logic [CODE_WIDTH-1:0] CMD_LASER_ON  = 7'd3;
   localparam logic [CODE_WIDTH-1:0] CMD_LASER_OFF = 7'd5;
   localparam logic [CODE_WIDTH-1:0] CMD_HOME      = 7'd28;
   localparam logic [CODE_WIDTH-1:0] CMD_SET_POS   = 7'd92;

   // Line prefix.
   typedef enum logic [1:0] {
      PFX_NONE  = 2'd0,
      PFX_G     = 2'd1,
      PFX_M     = 2'd2,
      PFX_OTHER = 2'd3
   } prefix_type;

   // Which field of the line the parser is in.
   typedef enum logic [5:0] {
      FLD_START = 6'b000001,
      FLD_CODE  = 6'b000010,
      FLD_X     = 6'b000100,
      FLD_Y     = 6'b001000,
      FLD_F     = 6'b010000,
      FLD_SKIP  = 6'b100000
   } field_type;

   // Result kind.
   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_ACK = 2'd0,
      KIND_X   = 2'd1,
      KIND_Y   = 2'd2
   } kind_type;

   // Segment phase of the back end.
   typedef enum logic [1:0] {
      PH_X = 2'b01,
      PH_Y = 2'b10
   } phase_type;

   // One finished line, handed from the parser to the segment generator.
   typedef struct packed {
      logic                   is_move;
      logic                   dir_x;
      logic                   y_up;
      logic [COORD_WIDTH-1:0] mag_x;
      logic [COORD_WIDTH-1:0] mag_y;
      logic                   laser;
      logic [FEED_WIDTH-1:0]  feed;
      logic [CODE_WIDTH-1:0]  code;
      logic                   is_m;
      logic [COORD_WIDTH-1:0] pos_x;
      logic [COORD_WIDTH-1:0] pos_y;
   } line_cmd_type;

   // Queue status.
   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

endpackage

@@ hw/rtl/gcmp_front.sv @@
module gcmp_front
   import gcmp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  char_valid,
   input  logic [CHAR_WIDTH-1:0] char_code,
   output logic                  cmd_push,
   output line_cmd_type          cmd_data
);

   logic [COORD_WIDTH-1:0] cur_x_ff, cur_x_in;
   logic [COORD_WIDTH-1:0] cur_y_ff, cur_y_in;
   logic [COORD_WIDTH-1:0] new_x_ff, new_x_in;
   logic [COORD_WIDTH-1:0] new_y_ff, new_y_in;
   prefix_type             prefix_ff, prefix_in;
   logic [CODE_WIDTH-1:0]  code_ff, code_in;
   field_type              field_ff, field_in;
   logic [COORD_WIDTH-1:0] acc_ff, acc_in;
   logic [FEED_WIDTH-1:0]  feed_ff, feed_in;
   logic                   laser_ff, laser_in;

   // Parser and line-end evaluation.
   always_comb begin
      logic                      is_digit;
      logic [3:0]                digit;
      logic [CODE_EXT_WIDTH-1:0] code_wide;
      logic [ACC_EXT_WIDTH-1:0]  acc_wide;
      logic [COORD_WIDTH-1:0]    nx;
      logic [COORD_WIDTH-1:0]    ny;
      logic [FEED_WIDTH-1:0]     feed_closed;
      logic                      do_move;
      logic                      pos_x_up;
      logic                      pos_y_up;

      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      new_x_in  = new_x_ff;
      new_y_in  = new_y_ff;
      prefix_in = prefix_ff;
      code_in   = code_ff;
      field_in  = field_ff;
      acc_in    = acc_ff;
      feed_in   = feed_ff;
      laser_in  = laser_ff;
      cmd_push  = 1'b0;
      cmd_data  = '0;

      is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      digit     = 4'(char_code - CHAR_ZERO);
      code_wide = CODE_EXT_WIDTH'(code_ff) * CODE_EXT_WIDTH'(10)
                  + CODE_EXT_WIDTH'(digit);
      acc_wide  = ACC_EXT_WIDTH'(acc_ff) * ACC_EXT_WIDTH'(10)
                  + ACC_EXT_WIDTH'(digit);

      // Values after closing the number that is being read.
      nx = (field_ff == FLD_X) ? acc_ff : new_x_ff;
      ny = (field_ff == FLD_Y) ? acc_ff : new_y_ff;
      feed_closed = feed_ff;
      if ((field_ff == FLD_F) && (prefix_ff == PFX_G) && (code_ff == CMD_LINEAR)) begin
         feed_closed = (acc_ff > COORD_WIDTH'(FEED_MAX)) ? FEED_MAX : FEED_WIDTH'(acc_ff);
      end

      do_move  = 1'b0;
      pos_x_up = 1'b0;
      pos_y_up = 1'b0;

      if (char_valid) begin
         if ((char_code == CHAR_LF) || (char_code == CHAR_CR)) begin
            // End of line: apply the command and hand a line word to the back end.
            feed_in = feed_closed;
            if (prefix_ff == PFX_G) begin
               if ((code_ff == CMD_RAPID) || (code_ff == CMD_LINEAR)) begin
                  do_move = 1'b1;
               end else if ((code_ff == CMD_HOME) || (code_ff == CMD_SET_POS)) begin
                  nx      = '0;
                  ny      = '0;
                  do_move = 1'b1;
               end
            end else if (prefix_ff == PFX_M) begin
               if (code_ff == CMD_LASER_ON) begin
                  laser_in = 1'b1;
               end else if (code_ff == CMD_LASER_OFF) begin
                  laser_in = 1'b0;
               end
            end

            pos_x_up = nx > cur_x_ff;
            pos_y_up = ny > cur_y_ff;
            if (do_move) begin
               cur_x_in = nx;
               cur_y_in = ny;
            end

            cmd_push         = 1'b1;
            cmd_data.is_move = do_move;
            cmd_data.dir_x   = !pos_x_up;
            cmd_data.y_up    = pos_y_up;
            cmd_data.mag_x   = pos_x_up ? (nx - cur_x_ff) : (cur_x_ff - nx);
            cmd_data.mag_y   = pos_y_up ? (ny - cur_y_ff) : (cur_y_ff - ny);
            cmd_data.laser   = laser_in;
            cmd_data.feed    = feed_closed;
            cmd_data.code    = code_ff;
            cmd_data.is_m    = (prefix_ff == PFX_M);
            cmd_data.pos_x   = cur_x_in;
            cmd_data.pos_y   = cur_y_in;

            new_x_in  = cur_x_in;
            new_y_in  = cur_y_in;
            prefix_in = PFX_NONE;
            code_in   = '0;
            field_in  = FLD_START;
            acc_in    = '0;
         end else if (field_ff == FLD_START) begin
            // First character of the line is the prefix.
            if (char_code == CHAR_G) begin
               prefix_in = PFX_G;
            end else if (char_code == CHAR_M) begin
               prefix_in = PFX_M;
            end else begin
               prefix_in = PFX_OTHER;
            end
            field_in = FLD_CODE;
         end else if (is_digit) begin
            // Digits extend the code or the current number, with saturation.
            if (field_ff == FLD_CODE) begin
               code_in = (code_wide > CODE_EXT_WIDTH'(CODE_MAX)) ?
                         CODE_MAX : CODE_WIDTH'(code_wide);
            end else if ((field_ff == FLD_X) || (field_ff == FLD_Y) ||
                         (field_ff == FLD_F)) begin
               acc_in = (acc_wide > ACC_EXT_WIDTH'(COORD_MAX)) ?
                        COORD_MAX : COORD_WIDTH'(acc_wide);
            end
         end else begin
            // Any other character closes the number and may open a new field.
            new_x_in = nx;
            new_y_in = ny;
            feed_in  = feed_closed;
            acc_in   = '0;
            if (char_code == CHAR_X) begin
               field_in = FLD_X;
            end else if (char_code == CHAR_Y) begin
               field_in = FLD_Y;
            end else if (char_code == CHAR_F) begin
               field_in = FLD_F;
            end else begin
               field_in = FLD_SKIP;
            end
         end
      end
   end

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         new_x_ff  <= '0;
         new_y_ff  <= '0;
         prefix_ff <= PFX_NONE;
         code_ff   <= '0;
         field_ff  <= FLD_START;
         acc_ff    <= '0;
         feed_ff   <= '0;
         laser_ff  <= 1'b0;
      end else begin
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         new_x_ff  <= new_x_in;
         new_y_ff  <= new_y_in;
         prefix_ff <= prefix_in;
         code_ff   <= code_in;
         field_ff  <= field_in;
         acc_ff    <= acc_in;
         feed_ff   <= feed_in;
         laser_ff  <= laser_in;
      end
   end

endmodule

@@ hw/rtl/gcmp_line_fifo.sv @@
module gcmp_line_fifo
   import gcmp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  line_cmd_type    push_data,
   input  logic            pop,
   output line_cmd_type    head,
   output fifo_status_type status
);

   line_cmd_type              entry_ff [LINE_FIFO_DEPTH];
   logic [LINE_FIFO_ADDR-1:0] wr_ptr_ff, wr_ptr_in;
   logic [LINE_FIFO_ADDR-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LINE_FIFO_ADDR:0]   count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   // Queue status and pointer updates.
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (LINE_FIFO_ADDR+1)'(LINE_FIFO_DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LINE_FIFO_ADDR'(LINE_FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LINE_FIFO_ADDR'(LINE_FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/gcmp_back.sv @@
module gcmp_back
   import gcmp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [STEPS_WIDTH-1:0] csr_wr_data,
   input  line_cmd_type           head,
   input  fifo_status_type        status,
   output logic                   cmd_pop,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output logic [KIND_WIDTH-1:0]  rsp_result_kind,
   output logic                   rsp_dir_motor_a,
   output logic                   rsp_dir_motor_b,
   output logic [PULSE_WIDTH-1:0] rsp_pulse_count,
   output logic                   rsp_laser_on,
   output logic [FEED_WIDTH-1:0]  rsp_feed_rate,
   output logic [CODE_WIDTH-1:0]  rsp_command_code,
   output logic                   rsp_is_m_command,
   output logic [POS_WIDTH-1:0]   rsp_pos_x,
   output logic [POS_WIDTH-1:0]   rsp_pos_y,
   output logic                   rsp_last
);

   logic [STEPS_WIDTH-1:0] steps_ff;
   phase_type              phase_ff, phase_in;
   logic                   valid_ff, valid_in;
   kind_type               kind_ff, kind_in;
   logic                   dir_a_ff, dir_a_in;
   logic                   dir_b_ff, dir_b_in;
   logic [PULSE_WIDTH-1:0] pulse_ff, pulse_in;
   logic                   laser_ff, laser_in;
   logic [FEED_WIDTH-1:0]  feed_ff, feed_in;
   logic [CODE_WIDTH-1:0]  code_ff, code_in;
   logic                   is_m_ff, is_m_in;
   logic [COORD_WIDTH-1:0] pos_x_ff, pos_x_in;
   logic [COORD_WIDTH-1:0] pos_y_ff, pos_y_in;
   logic                   last_ff, last_in;

   logic                   load;
   logic [COORD_WIDTH-1:0] mag_sel;
   logic [PROD_WIDTH-1:0]  product;
   logic [PULSE_WIDTH-1:0] pulses;

   // Pulse count of the current phase: twice steps times distance, saturated.
   assign mag_sel = (phase_ff == PH_Y) ? head.mag_y : head.mag_x;
   assign product = (PROD_WIDTH'(steps_ff) * PROD_WIDTH'(mag_sel)) << 1;
   assign pulses  = (product > PROD_WIDTH'(PULSE_MAX)) ? PULSE_MAX : PULSE_WIDTH'(product);

   // The output word can be refilled when it is empty or being taken.
   assign load = !valid_ff || rsp_pop;

   always_comb begin
      phase_in = phase_ff;
      valid_in = valid_ff && !rsp_pop;
      cmd_pop  = 1'b0;
      kind_in  = kind_ff;
      dir_a_in = dir_a_ff;
      dir_b_in = dir_b_ff;
      pulse_in = pulse_ff;
      laser_in = laser_ff;
      feed_in  = feed_ff;
      code_in  = code_ff;
      is_m_in  = is_m_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      last_in  = last_ff;

      if (!status.empty && load) begin
         valid_in = 1'b1;
         laser_in = head.laser;
         feed_in  = head.feed;
         code_in  = head.code;
         is_m_in  = head.is_m;
         pos_x_in = head.pos_x;
         pos_y_in = head.pos_y;
         if (head.is_move) begin
            unique case (phase_ff)
               PH_X: begin
                  kind_in  = KIND_X;
                  dir_a_in = head.dir_x;
                  dir_b_in = head.dir_x;
                  pulse_in = pulses;
                  last_in  = 1'b0;
                  phase_in = PH_Y;
               end
               PH_Y: begin
                  kind_in  = KIND_Y;
                  dir_a_in = !head.y_up;
                  dir_b_in = head.y_up;
                  pulse_in = pulses;
                  last_in  = 1'b1;
                  phase_in = PH_X;
                  cmd_pop  = 1'b1;
               end
               default: begin
                  phase_in = PH_X;
               end
            endcase
         end else begin
            // Lines without motion give a single acknowledge word.
            kind_in  = KIND_ACK;
            dir_a_in = 1'b0;
            dir_b_in = 1'b0;
            pulse_in = '0;
            last_in  = 1'b1;
            cmd_pop  = 1'b1;
         end
      end
   end

   // Control state and configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= STEPS_RESET;
         phase_ff <= PH_X;
         valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            steps_ff <= csr_wr_data;
         end
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   // Output word payload.
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      dir_a_ff <= dir_a_in;
      dir_b_ff <= dir_b_in;
      pulse_ff <= pulse_in;
      laser_ff <= laser_in;
      feed_ff  <= feed_in;
      code_ff  <= code_in;
      is_m_ff  <= is_m_in;
      pos_x_ff <= pos_x_in;
      pos_y_ff <= pos_y_in;
      last_ff  <= last_in;
   end

   assign rsp_empty        = !valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_dir_motor_a  = dir_a_ff;
   assign rsp_dir_motor_b  = dir_b_ff;
   assign rsp_pulse_count  = pulse_ff;
   assign rsp_laser_on     = laser_ff;
   assign rsp_feed_rate    = feed_ff;
   assign rsp_command_code = code_ff;
   assign rsp_is_m_command = is_m_ff;
   assign rsp_pos_x        = POS_WIDTH'(pos_x_ff);
   assign rsp_pos_y        = POS_WIDTH'(pos_y_ff);
   assign rsp_last         = last_ff;

endmodule

@@ hw/rtl/gcode_corexy_move_planner_core.sv @@
// CoreXY G-code move planner.
// Input queue port: one ASCII character of a G-code line per word, pushed with
// req_push while req_full is low. CR or LF ends the line and applies it.
// Result queue port: while rsp_empty is low the oldest result word is on the
// rsp_ ports; rsp_pop takes it. A G0, G1, G28 or G92 line gives two words, the
// X phase and then the Y phase with CoreXY directions and pulse counts; every
// other line gives one acknowledge word. rsp_last marks the final word of a line.
// csr_wr_en with csr_wr_data sets steps per unit; write it only while idle.
// The first result word of a line is written into the line queue at the edge that
// accepts its line end and then into the output register; a moving line's second
// word enters the output register at the edge that takes the first.
// Throughput: one character per cycle while req_full is low. The parser finishes
// a line in the cycle its line end is taken and queues it in a four-entry line
// queue; while each word is taken, the segment generator drains one result
// word per cycle into the output register. If the receiver stalls, results wait
// in the output register and the line queue; req_full rises only when it fills.
// Reset clears the position, feedrate, laser flag and queues, and sets steps
// per unit to one.
module gcode_corexy_move_planner_core
   import gcmp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [CHAR_WIDTH-1:0]  req_char_code,
   input  logic                   csr_wr_en,
   input  logic [STEPS_WIDTH-1:0] csr_wr_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [KIND_WIDTH-1:0]  rsp_result_kind,
   output logic                   rsp_dir_motor_a,
   output logic                   rsp_dir_motor_b,
   output logic [PULSE_WIDTH-1:0] rsp_pulse_count,
   output logic                   rsp_laser_on,
   output logic [FEED_WIDTH-1:0]  rsp_feed_rate,
   output logic [CODE_WIDTH-1:0]  rsp_command_code,
   output logic                   rsp_is_m_command,
   output logic [POS_WIDTH-1:0]   rsp_pos_x,
   output logic [POS_WIDTH-1:0]   rsp_pos_y,
   output logic                   rsp_last
);

   fifo_status_type status;
   line_cmd_type    push_data;
   line_cmd_type    head;
   logic            cmd_push;
   logic            cmd_pop;
   logic            char_valid;

   // A character is taken whenever the line queue has room.
   assign req_full   = status.full;
   assign char_valid = req_push && !status.full;

   gcmp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .char_valid (char_valid),
      .char_code  (req_char_code),
      .cmd_push   (cmd_push),
      .cmd_data   (push_data)
   );

   gcmp_line_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_data),
      .pop       (cmd_pop),
      .head      (head),
      .status    (status)
   );

   gcmp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .head             (head),
      .status           (status),
      .cmd_pop          (cmd_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_dir_motor_a  (rsp_dir_motor_a),
      .rsp_dir_motor_b  (rsp_dir_motor_b),
      .rsp_pulse_count  (rsp_pulse_count),
      .rsp_laser_on     (rsp_laser_on),
      .rsp_feed_rate    (rsp_feed_rate),
      .rsp_command_code (rsp_command_code),
      .rsp_is_m_command (rsp_is_m_command),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_last         (rsp_last)
   );

endmodule
